>>> rtl/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg: shared types and constants for the A x B^T matrix product block
// Element, index and accumulator widths, opcodes, controller state and the
// command/status words passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mmt_pkg;

  localparam int DIM_DEFAULT = 16;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 16;
  localparam int MUL_W  = 2 * ELEM_W;
  localparam int ACC_W  = 39;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ_C  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH,
    ST_DONE
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_a;      // store in_value into A
    logic wr_b;      // store in_value into B
    logic start;     // latch row/col, clear accumulator and k
    logic issue;     // read element pair k, advance k
    logic load_out;  // move accumulator into the output register
  } mmt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;  // in_row and in_col both below DIM
    logic last_k;    // k is at DIM-1
    logic pipe_busy; // multiply/accumulate stages still hold data
  } mmt_sts_t;

endpackage

`default_nettype wire

>>> rtl/mmt_ram.sv
// ----------------------------------------------------------------------------
// mmt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/mmt_ctrl.sv
// ----------------------------------------------------------------------------
// mmt_ctrl: sequencing state machine
// Accepts words, issues writes, walks k over a dot product, owns out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [mmt_pkg::OP_W-1:0] in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  mmt_pkg::mmt_sts_t        sts,
  output mmt_pkg::mmt_cmd_t        cmd
);

  import mmt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_WRITE_A: cmd.wr_a = sts.in_range;
            OP_WRITE_B: cmd.wr_b = sts.in_range;
            OP_READ_C: begin
              cmd.start = 1'b1;
              state_nxt = sts.in_range ? ST_ISSUE : ST_DONE;
            end
            default: ;  // unused opcode: dropped
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.last_k) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // result is handed over only once the pipeline has drained
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && !sts.pipe_busy) |=> (state_r == ST_DONE))
    else $error("flush did not complete");

  // a waiting word stays up until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped before handshake");

endmodule

`default_nettype wire

>>> rtl/mmt_dp.sv
// ----------------------------------------------------------------------------
// mmt_dp: matrix storage and multiply-accumulate datapath
// Two element RAMs, k counter, registered multiplier, accumulator, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_dp #(
  parameter int DIM = mmt_pkg::DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mmt_pkg::IDX_W-1:0]         in_row,
  input  logic [mmt_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mmt_pkg::ELEM_W-1:0] in_value,
  input  mmt_pkg::mmt_cmd_t                 cmd,
  output mmt_pkg::mmt_sts_t                 sts,
  output logic signed [mmt_pkg::ACC_W-1:0]  out_product
);

  import mmt_pkg::*;

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (DIM > 1) ? $clog2(DIM) : 1;

  logic [IDX_W-1:0]        row_r, col_r;
  logic [KW-1:0]           k_r;
  logic [AW-1:0]           waddr, raddr_a, raddr_b;
  logic [ELEM_W-1:0]       rd_a, rd_b;
  logic                    v1_r, v2_r;
  logic signed [MUL_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] product_r;

  assign sts.in_range  = (32'(in_row) < DIM) && (32'(in_col) < DIM);
  assign sts.last_k    = (k_r == KW'(DIM - 1));
  assign sts.pipe_busy = v1_r | v2_r;

  // row-major addressing, multiply by a constant
  assign waddr   = AW'(in_row) * AW'(DIM) + AW'(in_col);
  assign raddr_a = AW'(row_r) * AW'(DIM) + AW'(k_r);
  assign raddr_b = AW'(col_r) * AW'(DIM) + AW'(k_r);

  mmt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  mmt_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  assign prod_ext = {{(ACC_W - MUL_W){prod_r[MUL_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= in_row;
      col_r <= in_col;
      k_r   <= '0;
    end else if (cmd.issue) begin
      k_r <= k_r + KW'(1);
    end
    if (v1_r) begin
      prod_r <= $signed(rd_a) * $signed(rd_b);
    end
    if (cmd.start) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + prod_ext;
    end
    if (cmd.load_out) begin
      product_r <= acc_r;
    end
  end

  assign out_product = product_r;

  // stores only happen with the pipeline empty
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_a || cmd.wr_b) |-> !(v1_r || v2_r))
    else $error("element write during dot product");

  // a new read starts from a cleared accumulator
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (acc_r == '0))
    else $error("accumulator not cleared");

  // result is loaded only after the last product was added
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(v1_r || v2_r))
    else $error("result loaded before accumulation finished");

endmodule

`default_nettype wire

>>> rtl/matrix_multiply_transposed.sv
// ----------------------------------------------------------------------------
// matrix_multiply_transposed: C = A x B^T, one element per read word
// Element writes into A or B; a read word returns C[row][col] computed by a
// multiply-accumulate walk over row 'row' of A and row 'col' of B.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_op, in_row, in_col, in_value
//   out_     output     out_valid/out_ready  out_product
//
// Sequence: a write or an unused opcode is done in the accept step alone. A read in
//   range runs accept, DIM pair reads, a drain through RAM read, multiply and
//   add, then handoff, with one shared MAC and one read port per RAM.
// Reset: rst_n, synchronous, clears controller state and out_valid; RAMs are
//   undefined until written. An out-of-range read skips the k walk, product 0.
// Stalls: a new word is taken while a result waits; a read finishing into a
//   still-full output holds in handoff.
`default_nettype none

module matrix_multiply_transposed #(
  parameter int DIM = mmt_pkg::DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mmt_pkg::OP_W-1:0]          in_op,
  input  logic [mmt_pkg::IDX_W-1:0]         in_row,
  input  logic [mmt_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mmt_pkg::ELEM_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mmt_pkg::ACC_W-1:0]  out_product
);

  import mmt_pkg::*;

  mmt_cmd_t cmd;
  mmt_sts_t sts;

  // sequencer: handshakes and command generation
  mmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, MAC pipeline and output word register
  mmt_dp #(.DIM(DIM)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_value    (in_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_product (out_product)
  );

endmodule

`default_nettype wire
